// ===== hdl/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types and constants of the accumulator machine execute core.
// ----------------------------------------------------------------------------
package ame_pkg;

   // fixed widths of the beat fields
   localparam int FIELD_WIDTH  = 16;
   localparam int OPCODE_WIDTH = 4;
   localparam int STATUS_WIDTH = 2;

   // parameter defaults
   localparam int DATA_WIDTH_DEFAULT = 16;
   localparam int MEM_DEPTH_DEFAULT  = 256;
   localparam int PC_STEP_DEFAULT    = 2;

   // action codes
   localparam logic ACT_EXECUTE = 1'b0;
   localparam logic ACT_PRELOAD = 1'b1;

   // opcodes
   localparam logic [OPCODE_WIDTH-1:0] OP_ADD   = 4'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_AND   = 4'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_OR    = 4'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_XOR   = 4'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_LOAD  = 4'd4;
   localparam logic [OPCODE_WIDTH-1:0] OP_STORE = 4'd5;
   localparam logic [OPCODE_WIDTH-1:0] OP_JUMP  = 4'd6;
   localparam logic [OPCODE_WIDTH-1:0] OP_JNZ   = 4'd7;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OPCODE = 2'd2;

   // one result beat
   typedef struct packed {
      logic [FIELD_WIDTH-1:0]  acc_out;
      logic [FIELD_WIDTH-1:0]  pc_out;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_type;

endpackage

// ===== hdl/ame_ram.sv =====
// ----------------------------------------------------------------------------
// ame_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ame_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/accumulator_machine_execute_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_execute_core
// Executes one accumulator machine instruction or one memory preload per beat.
// ----------------------------------------------------------------------------
// A request beat is registered into the execute stage registers, executed there and then
//   written into the result queue; rsp_valid rises once the queue holds it
// throughput: one beat per cycle while the result queue has room, set by the single
//   data memory read port and the execute stage that reads, modifies and writes it back
// reset: accumulator and program counter clear at once; the data memory is then
//   cleared one word a cycle, req_ready low
module accumulator_machine_execute_core #(
   parameter int DATA_WIDTH = ame_pkg::DATA_WIDTH_DEFAULT,
   parameter int MEM_DEPTH  = ame_pkg::MEM_DEPTH_DEFAULT,
   parameter int PC_STEP    = ame_pkg::PC_STEP_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [ame_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  logic [ame_pkg::FIELD_WIDTH-1:0]     req_address,
   input  logic [ame_pkg::FIELD_WIDTH-1:0]     req_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ame_pkg::FIELD_WIDTH-1:0]     rsp_acc_out,
   output logic [ame_pkg::FIELD_WIDTH-1:0]     rsp_pc_out,
   output logic [ame_pkg::STATUS_WIDTH-1:0]    rsp_status
);

   localparam int MAW       = $clog2(MEM_DEPTH);
   localparam int OQ_DEPTH  = 3;
   localparam int OQ_PTR_W  = 2;
   localparam int OQ_CNT_W  = 2;

   // ------------------------------------------------------------------------
   // memory clear after reset
   // ------------------------------------------------------------------------
   logic           clearing_ff, clearing_in;
   logic [MAW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + MAW'(1);
         if (clr_addr_ff == MAW'(MEM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ------------------------------------------------------------------------
   // issue: mask the operand and start the memory read
   // ------------------------------------------------------------------------
   logic                  req_accept;
   logic [DATA_WIDTH-1:0] req_addr_m;
   logic [DATA_WIDTH-1:0] req_value_m;
   logic [MAW-1:0]        req_idx;
   logic                  req_in_mem;

   assign req_accept  = req_valid && req_ready;
   assign req_addr_m  = DATA_WIDTH'(req_address);
   assign req_value_m = DATA_WIDTH'(req_value);
   assign req_idx     = MAW'(req_addr_m);
   assign req_in_mem  = 32'(req_addr_m) < 32'(MEM_DEPTH);

   // execute stage registers
   logic                              s1_valid_ff;
   logic                              s1_action_ff;
   logic [ame_pkg::OPCODE_WIDTH-1:0]  s1_opcode_ff;
   logic [DATA_WIDTH-1:0]             s1_addr_ff;
   logic [DATA_WIDTH-1:0]             s1_value_ff;
   logic [MAW-1:0]                    s1_idx_ff;
   logic                              s1_in_mem_ff;
   logic                              byp_hit_ff, byp_hit_in;
   logic [DATA_WIDTH-1:0]             byp_data_ff;

   // architectural state
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] pc_ff, pc_in;

   // execute stage outputs
   logic                              ex_we;
   logic [DATA_WIDTH-1:0]             ex_wdata;
   logic [ame_pkg::STATUS_WIDTH-1:0]  ex_status;
   logic [DATA_WIDTH-1:0]             ex_word;
   logic [DATA_WIDTH-1:0]             pc_adv;
   logic [DATA_WIDTH-1:0]             rd_data;

   // memory port selection
   logic                  mem_we;
   logic [MAW-1:0]        mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   assign mem_we    = clearing_ff ? 1'b1 : ex_we;
   assign mem_waddr = clearing_ff ? clr_addr_ff : s1_idx_ff;
   assign mem_wdata = clearing_ff ? '0 : ex_wdata;

   ame_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   // the word being written now is what the next read must see
   assign byp_hit_in = s1_valid_ff && ex_we && (s1_idx_ff == req_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_opcode_ff <= req_opcode;
         s1_addr_ff   <= req_addr_m;
         s1_value_ff  <= req_value_m;
         s1_idx_ff    <= req_idx;
         s1_in_mem_ff <= req_in_mem;
         byp_hit_ff   <= byp_hit_in;
         byp_data_ff  <= ex_wdata;
      end
   end

   // ------------------------------------------------------------------------
   // execute: read, modify, write back
   // ------------------------------------------------------------------------
   assign ex_word = byp_hit_ff ? byp_data_ff : rd_data;
   assign pc_adv  = pc_ff + DATA_WIDTH'(PC_STEP);

   always_comb begin
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      ex_we     = 1'b0;
      ex_wdata  = s1_value_ff;
      ex_status = ame_pkg::ST_OK;
      if (s1_valid_ff) begin
         if (s1_action_ff == ame_pkg::ACT_PRELOAD) begin
            if (s1_in_mem_ff) begin
               ex_we = 1'b1;
            end else begin
               ex_status = ame_pkg::ST_RANGE;
            end
         end else begin
            case (s1_opcode_ff)
               ame_pkg::OP_JUMP: begin
                  pc_in = s1_addr_ff;
               end
               ame_pkg::OP_JNZ: begin
                  pc_in = (acc_ff != '0) ? s1_addr_ff : pc_adv;
               end
               ame_pkg::OP_ADD, ame_pkg::OP_AND, ame_pkg::OP_OR, ame_pkg::OP_XOR,
               ame_pkg::OP_LOAD, ame_pkg::OP_STORE: begin
                  if (!s1_in_mem_ff) begin
                     ex_status = ame_pkg::ST_RANGE;
                  end else begin
                     pc_in = pc_adv;
                     case (s1_opcode_ff)
                        ame_pkg::OP_ADD:  acc_in = acc_ff + ex_word;
                        ame_pkg::OP_AND:  acc_in = acc_ff & ex_word;
                        ame_pkg::OP_OR:   acc_in = acc_ff | ex_word;
                        ame_pkg::OP_XOR:  acc_in = acc_ff ^ ex_word;
                        ame_pkg::OP_LOAD: acc_in = ex_word;
                        default: begin
                           ex_we    = 1'b1;
                           ex_wdata = acc_ff;
                        end
                     endcase
                  end
               end
               default: begin
                  ex_status = ame_pkg::ST_OPCODE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pc_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
         pc_ff  <= pc_in;
      end
   end

   // ------------------------------------------------------------------------
   // result queue, room for every beat in flight
   // ------------------------------------------------------------------------
   ame_pkg::rsp_type      oq_ff [OQ_DEPTH];
   ame_pkg::rsp_type      oq_entry;
   logic [OQ_PTR_W-1:0]   oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0]   oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0]   oq_count_ff, oq_count_in;
   logic                  oq_push, oq_pop;
   logic [OQ_CNT_W:0]     oq_load;

   assign oq_push = s1_valid_ff;
   assign oq_pop  = rsp_valid && rsp_ready;

   assign oq_entry.acc_out = ame_pkg::FIELD_WIDTH'(acc_in);
   assign oq_entry.pc_out  = ame_pkg::FIELD_WIDTH'(pc_in);
   assign oq_entry.status  = ex_status;

   always_comb begin
      oq_wr_in    = oq_wr_ff;
      oq_rd_in    = oq_rd_ff;
      oq_count_in = oq_count_ff;
      if (oq_push) begin
         oq_wr_in = (oq_wr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_ff + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
         oq_rd_in = (oq_rd_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_ff + OQ_PTR_W'(1);
      end
      if (oq_push && !oq_pop) begin
         oq_count_in = oq_count_ff + OQ_CNT_W'(1);
      end else if (!oq_push && oq_pop) begin
         oq_count_in = oq_count_ff - OQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_entry;
      end
   end

   // queued beats plus the one in execute never exceed the queue
   assign oq_load   = {1'b0, oq_count_ff} + (OQ_CNT_W + 1)'(s1_valid_ff);
   assign req_ready = !clearing_ff && (oq_load < (OQ_CNT_W + 1)'(OQ_DEPTH));

   assign rsp_valid   = oq_count_ff != '0;
   assign rsp_acc_out = oq_ff[oq_rd_ff].acc_out;
   assign rsp_pc_out  = oq_ff[oq_rd_ff].pc_out;
   assign rsp_status  = oq_ff[oq_rd_ff].status;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (oq_push && oq_count_ff == OQ_CNT_W'(OQ_DEPTH)) |-> oq_pop)
      else $error("result queue overflow");

   a_no_exec_in_clear: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !clearing_ff)
      else $error("instruction executed during memory clear");

   a_pc_idle_stable: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |=> $stable(pc_ff) && $stable(acc_ff))
      else $error("state changed with no beat in execute");

   a_bypass_source: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_valid_ff && ex_we && s1_idx_ff == req_idx) |=> byp_hit_ff)
      else $error("missed forward of a pending memory write");

endmodule
